/* rtl/ethmr_pkg.sv */
// ethmr_pkg: shared types, constants and helper functions of the mac rewriter
// used by every module under rtl but ethmr_fifo, depends on nothing
`default_nettype none
package ethmr_pkg;

  localparam int CFG_IDX_W    = 8;
  localparam int MAC_W        = 48;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 104;
  localparam int HDR_BYTES    = 38;
  localparam int REL_BYTES    = 42;
  localparam int DQ_DEPTH     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HOST_MAC  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUEST_MAC = 8'd1;

  localparam logic [15:0] ETH_ARP     = 16'h0806;
  localparam logic [15:0] ETH_IP      = 16'h0800;
  localparam logic [7:0]  IP_UDP      = 8'd17;
  localparam logic [15:0] PORT_SERVER = 16'd67;
  localparam logic [15:0] PORT_CLIENT = 16'd68;
  localparam logic [7:0]  HTYPE_ETH   = 8'd1;
  localparam logic [7:0]  HLEN_ETH    = 8'd6;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } wrd_t;

  typedef struct packed {
    logic        dst_e;
    logic        src_e;
    logic        arp_e;
    logic [6:0]  arp_off;
    logic        dhcp_e;
    logic [6:0]  ch_off;
    logic        ck_e;
    logic [6:0]  ck_off;
    logic [15:0] ck_val;
    logic [47:0] to_mac;
    logic [31:0] gip;
    logic        learned;
  } dec_t;

  function automatic logic [7:0] lane_byte(input logic [63:0] w, input logic [2:0] lane);
    logic [2:0] rl;
    rl = 3'd7 - lane;
    return w[{rl, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] mac_byte(input logic [47:0] m, input logic [6:0] idx);
    logic [7:0] r;
    case (idx)
      7'd0: r = m[47:40];
      7'd1: r = m[39:32];
      7'd2: r = m[31:24];
      7'd3: r = m[23:16];
      7'd4: r = m[15:8];
      7'd5: r = m[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // sum of inverted old and new 16-bit chunks for the checksum update
  function automatic logic [18:0] ck_const(input logic [47:0] oldm, input logic [47:0] newm);
    logic [18:0] s;
    logic [15:0] t;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      t = ~oldm[16*i +: 16];
      s = s + 19'(t) + 19'(newm[16*i +: 16]);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/ethernet_mac_rewriter.sv */
// ethernet_mac_rewriter: top level, config registers, word and decision queues
// depends on ethmr_pkg, ethmr_fifo, ethmr_front, ethmr_back
//
// channel  dir  handshake                fields
// in_      in   in_tvalid/in_tready      tdata, tlast, tuser
// out_     out  out_tvalid/out_tready    tdata, tlast
// cfg_     in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
// one word per cycle sustained on both sides unless stalled; the word queue
// holds a frame's first DELAY_DEPTH words until its edit decision, registered
// in ethmr_front and the decision queue, reaches ethmr_back. a frame's first
// word leaves after its DELAY_DEPTH-th or last word arrives. reset is synchronous,
// no clearing pass; either side may stall freely, cfg_ready is always high
`default_nettype none
module ethernet_mac_rewriter import ethmr_pkg::*; #(
  parameter int DELAY_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // data_word, byte_count, zero pad
  input  wire logic                   in_tlast,
  input  wire logic                   in_tuser,   // to_guest
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // out_word, out_count, guest_ip,
                                                  // ip_learned, zero pad
  output logic                        out_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [MAC_W-1:0]       cfg_data
);
  localparam int WQ_DEPTH = 2 ** ($clog2(DELAY_DEPTH) + 1);

  logic [MAC_W-1:0] host_mac_r, guest_mac_r;
  logic             acc;
  logic             wq_afull, wq_valid, wq_pop;
  wrd_t             wq_in, wq_head;
  logic             dq_afull, dq_valid, dq_pop, dq_push;
  dec_t             dq_in, dq_head;

  assign cfg_ready = 1'b1;
  assign in_tready = !wq_afull && !dq_afull;
  assign acc       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_mac_r  <= '0;
      guest_mac_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOST_MAC:  host_mac_r  <= cfg_data;
        REG_GUEST_MAC: guest_mac_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wq_in.data  = in_tdata[63:0];
  assign wq_in.count = in_tdata[67:64];
  assign wq_in.last  = in_tlast;

  ethmr_front #(.DELAY_DEPTH(DELAY_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc),
    .data_word(in_tdata[63:0]), .byte_count(in_tdata[67:64]),
    .last(in_tlast), .to_guest(in_tuser),
    .host_mac(host_mac_r), .guest_mac(guest_mac_r),
    .dec_push(dq_push), .dec(dq_in)
  );

  ethmr_fifo #(.W($bits(wrd_t)), .DEPTH(WQ_DEPTH)) u_wq (
    .clk(clk), .rst_n(rst_n), .push(acc), .wdata(wq_in),
    .afull(wq_afull), .hvalid(wq_valid), .hdata(wq_head), .pop(wq_pop)
  );

  ethmr_fifo #(.W($bits(dec_t)), .DEPTH(DQ_DEPTH)) u_dq (
    .clk(clk), .rst_n(rst_n), .push(dq_push), .wdata(dq_in),
    .afull(dq_afull), .hvalid(dq_valid), .hdata(dq_head), .pop(dq_pop)
  );

  ethmr_back u_back (
    .clk(clk), .rst_n(rst_n),
    .wq_valid(wq_valid), .wq_head(wq_head), .wq_pop(wq_pop),
    .dq_valid(dq_valid), .dq_head(dq_head), .dq_pop(dq_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );
endmodule
`default_nettype wire

/* rtl/ethmr_fifo.sv */
// ethmr_fifo: memory queue with a registered head entry
// generic, depends on nothing; DEPTH must be a power of two
`default_nettype none
module ethmr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              afull,
  output logic              hvalid,
  output logic [W-1:0]      hdata,
  input  wire logic         pop
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          hv_r;
  logic [W-1:0]  hd_r;
  logic          load;

  assign load   = (cnt_r != '0) && (!hv_r || pop);
  assign afull  = cnt_r >= CW'(DEPTH - 1);
  assign hvalid = hv_r;
  assign hdata  = hd_r;

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
    if (load) hd_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      hv_r  <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (load) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + CW'(push) - CW'(load);
      if (load) begin
        hv_r <= 1'b1;
      end else if (pop) begin
        hv_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/ethmr_front.sv */
// ethmr_front: tracks frame position, captures header bytes and decides the edits
// depends on ethmr_pkg
`default_nettype none
module ethmr_front import ethmr_pkg::*; #(
  parameter int DELAY_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [63:0] data_word,
  input  wire logic [3:0]  byte_count,
  input  wire logic        last,
  input  wire logic        to_guest,
  input  wire logic [47:0] host_mac,
  input  wire logic [47:0] guest_mac,
  output logic             dec_push,
  output dec_t             dec
);
  localparam int POS_W = $clog2(DELAY_DEPTH + 1);
  localparam int LEN_W = $clog2(8 * DELAY_DEPTH + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             dir_r;
  logic [7:0]       hdr_r [HDR_BYTES];
  logic [7:0]       hdr_nxt [HDR_BYTES];
  logic [7:0]       rel_r [REL_BYTES];
  logic [7:0]       rel_nxt [REL_BYTES];
  logic             d1_v_r, d1_tg_r;
  logic [LEN_W-1:0] d1_len_r;
  logic [18:0]      k_tg_r, k_fg_r;
  logic [31:0]      lip_r, lip_nxt;

  logic             tg_cur, dec_now;
  logic [LEN_W-1:0] len_cur;
  logic [3:0]       cnt_clip;
  logic [7:0]       u_cap;

  assign cnt_clip = (byte_count > 4'd8) ? 4'd8 : byte_count;
  assign tg_cur   = (pos_r == '0) ? to_guest : dir_r;
  assign len_cur  = last ? (LEN_W'({pos_r, 3'b000}) + LEN_W'(cnt_clip))
                         : LEN_W'(8 * DELAY_DEPTH);
  assign dec_now  = acc && (last ? (pos_r < POS_W'(DELAY_DEPTH))
                                 : (pos_r == POS_W'(DELAY_DEPTH - 1)));
  assign u_cap    = 8'd14 + {2'b00, hdr_r[14][3:0], 2'b00};

  always_comb begin
    pos_nxt = pos_r;
    if (acc) begin
      if (last) begin
        pos_nxt = '0;
      end else if (pos_r < POS_W'(DELAY_DEPTH)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_comb begin
    logic [7:0] abs_k;
    abs_k = '0;
    for (int k = 0; k < HDR_BYTES; k++) begin
      hdr_nxt[k] = hdr_r[k];
      if (acc && pos_r == POS_W'(k >> 3)) hdr_nxt[k] = lane_byte(data_word, 3'(k & 7));
    end
    for (int k = 0; k < REL_BYTES; k++) begin
      rel_nxt[k] = rel_r[k];
      abs_k = u_cap + 8'(k);
      if (acc && pos_r >= POS_W'(2) && POS_W'(abs_k[7:3]) == pos_r)
        rel_nxt[k] = lane_byte(data_word, abs_k[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    hdr_r    <= hdr_nxt;
    rel_r    <= rel_nxt;
    d1_tg_r  <= tg_cur;
    d1_len_r <= len_cur;
    k_tg_r   <= ck_const(guest_mac, host_mac);
    k_fg_r   <= ck_const(host_mac, guest_mac);
    if (acc && pos_r == '0) dir_r <= to_guest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      d1_v_r <= 1'b0;
      lip_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      d1_v_r <= dec_now;
      if (d1_v_r) lip_r <= lip_nxt;
    end
  end

  // edit decision, formed in the cycle after the deciding word is taken
  logic [47:0] from_m, to_m, dmac, smac, amac_s, amac_t, chaddr;
  logic [15:0] et, sp, dp, ck_old, ck_new;
  logic [15:0] ck_inv;
  logic [3:0]  ihl;
  logic [6:0]  u;
  logic        l14, arp, arp_e, ip_ok, port_ok, dhcp_e, learn;
  logic [LEN_W-1:0] arp_need;
  logic [18:0] s0, kk;
  logic [16:0] f1;
  logic [16:0] f2;

  assign from_m = d1_tg_r ? guest_mac : host_mac;
  assign to_m   = d1_tg_r ? host_mac : guest_mac;
  assign dmac   = {hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3], hdr_r[4], hdr_r[5]};
  assign smac   = {hdr_r[6], hdr_r[7], hdr_r[8], hdr_r[9], hdr_r[10], hdr_r[11]};
  assign amac_s = {hdr_r[22], hdr_r[23], hdr_r[24], hdr_r[25], hdr_r[26], hdr_r[27]};
  assign amac_t = {hdr_r[32], hdr_r[33], hdr_r[34], hdr_r[35], hdr_r[36], hdr_r[37]};
  assign chaddr = {rel_r[36], rel_r[37], rel_r[38], rel_r[39], rel_r[40], rel_r[41]};
  assign et     = {hdr_r[12], hdr_r[13]};
  assign sp     = {rel_r[0], rel_r[1]};
  assign dp     = {rel_r[2], rel_r[3]};
  assign ck_old = {rel_r[6], rel_r[7]};
  assign ihl    = hdr_r[14][3:0];
  assign u      = 7'd14 + {1'b0, ihl, 2'b00};

  assign l14      = d1_len_r >= LEN_W'(14);
  assign arp      = l14 && et == ETH_ARP;
  assign arp_need = d1_tg_r ? LEN_W'(38) : LEN_W'(28);
  assign arp_e    = arp && d1_len_r >= arp_need && (d1_tg_r ? amac_t : amac_s) == from_m;
  assign ip_ok    = l14 && et == ETH_IP && d1_len_r >= LEN_W'(24) && ihl >= 4'd5
                    && hdr_r[23] == IP_UDP && (LEN_W'(u) + LEN_W'(42)) <= d1_len_r;
  assign port_ok  = d1_tg_r ? (sp == PORT_SERVER && dp == PORT_CLIENT)
                            : (sp == PORT_CLIENT && dp == PORT_SERVER);
  assign dhcp_e   = ip_ok && port_ok && rel_r[9] == HTYPE_ETH && rel_r[10] == HLEN_ETH
                    && chaddr == from_m;
  assign learn    = dhcp_e && d1_tg_r;
  assign lip_nxt  = learn ? {rel_r[24], rel_r[25], rel_r[26], rel_r[27]} : lip_r;

  assign ck_inv = ~ck_old;
  assign kk     = d1_tg_r ? k_tg_r : k_fg_r;
  assign s0     = 19'(ck_inv) + kk;
  assign f1     = 17'(s0[15:0]) + 17'(s0[18:16]);
  assign f2     = 17'(f1[15:0]) + 17'(f1[16]);
  assign ck_new = (~f2[15:0] == 16'h0000) ? 16'hFFFF : ~f2[15:0];

  assign dec_push    = d1_v_r;
  assign dec.dst_e   = d1_tg_r && d1_len_r >= LEN_W'(6) && dmac == from_m;
  assign dec.src_e   = !d1_tg_r && d1_len_r >= LEN_W'(12) && smac == from_m;
  assign dec.arp_e   = arp_e;
  assign dec.arp_off = d1_tg_r ? 7'd32 : 7'd22;
  assign dec.dhcp_e  = dhcp_e;
  assign dec.ch_off  = u + 7'd36;
  assign dec.ck_e    = dhcp_e && ck_old != 16'h0000;
  assign dec.ck_off  = u + 7'd6;
  assign dec.ck_val  = ck_new;
  assign dec.to_mac  = to_m;
  assign dec.gip     = lip_nxt;
  assign dec.learned = learn;
endmodule
`default_nettype wire

/* rtl/ethmr_back.sv */
// ethmr_back: applies a frame's edits to its words and drives the output register
// depends on ethmr_pkg
`default_nettype none
module ethmr_back import ethmr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wq_valid,
  input  wire wrd_t                   wq_head,
  output logic                        wq_pop,
  input  wire logic                   dq_valid,
  input  wire dec_t                   dq_head,
  output logic                        dq_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);
  logic        take;
  logic [4:0]  widx_r;
  logic        ov_r;
  logic [63:0] word_r, word_nxt;
  logic [3:0]  cnt_r;
  logic        last_r, lrn_r;
  logic [31:0] gip_r;

  assign take   = wq_valid && dq_valid && (!ov_r || out_tready);
  assign wq_pop = take;
  assign dq_pop = take && wq_head.last;

  always_comb begin
    logic [6:0] b, d;
    logic [7:0] v;
    b = '0;
    d = '0;
    v = '0;
    word_nxt = wq_head.data;
    for (int j = 0; j < 8; j++) begin
      b = {widx_r[3:0], 3'(j)};
      v = lane_byte(wq_head.data, 3'(j));
      if (!widx_r[4]) begin
        if (dq_head.dst_e && b < 7'd6) v = mac_byte(dq_head.to_mac, b);
        if (dq_head.src_e && b >= 7'd6 && b < 7'd12) v = mac_byte(dq_head.to_mac, b - 7'd6);
        d = b - dq_head.arp_off;
        if (dq_head.arp_e && d < 7'd6) v = mac_byte(dq_head.to_mac, d);
        d = b - dq_head.ch_off;
        if (dq_head.dhcp_e && d < 7'd6) v = mac_byte(dq_head.to_mac, d);
        d = b - dq_head.ck_off;
        if (dq_head.ck_e && d == 7'd0) v = dq_head.ck_val[15:8];
        if (dq_head.ck_e && d == 7'd1) v = dq_head.ck_val[7:0];
      end
      word_nxt[8*(7-j) +: 8] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= word_nxt;
      cnt_r  <= wq_head.count;
      last_r <= wq_head.last;
      gip_r  <= dq_head.gip;
      lrn_r  <= dq_head.learned;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      widx_r <= '0;
    end else begin
      if (take) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      if (take) begin
        if (wq_head.last) begin
          widx_r <= '0;
        end else if (!widx_r[4]) begin
          widx_r <= widx_r + 5'd1;
        end
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {3'b000, lrn_r, gip_r, cnt_r, word_r};
endmodule
`default_nettype wire

/* sim/ethernet_mac_rewriter_tb.sv */
// ethernet_mac_rewriter_tb: self-checking testbench for the mac rewriter
// builds ethernet, arp and dhcp frames, predicts every rewritten word and checks
// the output stream; depends on ethmr_pkg and the ethernet_mac_rewriter rtl
`default_nettype none
module ethernet_mac_rewriter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ethmr_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        tg;
  } frame_word_t;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [31:0] ip;
    logic        learned;
  } out_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MAC_W-1:0] cfg_data = '0;

  ethernet_mac_rewriter #(.DELAY_DEPTH(DEPTH)) DUT (.*);

  always #10 clk = ~clk;

  // rewriter model state
  logic [63:0] line_w[DEPTH];
  logic [3:0]  line_c[DEPTH];
  int          line_pos;
  logic        frame_tg, frame_learned;
  logic [31:0] learned_ip;
  logic [47:0] host_mac, guest_mac;

  frame_word_t pending_words[$];
  out_word_t   expected_words[$];
  frame_word_t cur;
  bit          took;
  bit          no_idle;
  int          errors;

  function automatic logic [7:0] get8(int b);
    if ((b >> 3) >= DEPTH) return 8'h00;
    return line_w[b >> 3][63 - 8 * (b & 7) -: 8];
  endfunction

  function automatic void put8(int b, logic [7:0] v);
    if ((b >> 3) >= DEPTH) return;
    line_w[b >> 3][63 - 8 * (b & 7) -: 8] = v;
  endfunction

  function automatic logic [63:0] getn(int b, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = {v[55:0], get8(b + i)};
    return v;
  endfunction

  function automatic void putn(int b, int n, logic [63:0] v);
    for (int i = 0; i < n; i++) put8(b + i, v[8 * (n - 1 - i) +: 8]);
  endfunction

  function automatic logic [15:0] mac_delta(logic [47:0] oldm, logic [47:0] newm);
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) s = s + {16'h0, ~oldm[16 * i +: 16]} + {16'h0, newm[16 * i +: 16]};
    s = (s & 32'hFFFF) + (s >> 16);
    s = (s & 32'hFFFF) + (s >> 16);
    return s[15:0];
  endfunction

  function automatic void decide_edits(int len);
    logic [47:0] frm, too;
    logic [31:0] s;
    logic [15:0] c;
    int et, ihl, u, bp, sp, dp, off;
    frm = frame_tg ? guest_mac : host_mac;
    too = frame_tg ? host_mac : guest_mac;
    if (frame_tg) begin
      if (len >= 6 && getn(0, 6) == frm) putn(0, 6, too);
    end else if (len >= 12 && getn(6, 6) == frm) begin
      putn(6, 6, too);
    end
    if (len < 14) return;
    et = int'(getn(12, 2));
    if (et == ETH_ARP) begin
      off = frame_tg ? 32 : 22;
      if (len >= off + 6 && getn(off, 6) == frm) putn(off, 6, too);
      return;
    end
    if (et != ETH_IP || len < 24) return;
    ihl = get8(14) & 15;
    if (ihl < 5 || get8(23) != IP_UDP) return;
    u = 14 + 4 * ihl;
    bp = u + 8;
    if (bp + 34 > len) return;
    sp = int'(getn(u, 2));
    dp = int'(getn(u + 2, 2));
    if (frame_tg ? (sp != PORT_SERVER || dp != PORT_CLIENT)
                 : (sp != PORT_CLIENT || dp != PORT_SERVER)) return;
    if (get8(bp + 1) != HTYPE_ETH || get8(bp + 2) != HLEN_ETH) return;
    if (getn(bp + 28, 6) != frm) return;
    c = 16'(getn(u + 6, 2));
    if (c != 16'h0) begin
      s = {16'h0, ~c};
      for (int i = 0; i < 3; i++)
        s = s + {16'h0, ~frm[32 - 16 * i +: 16]} + {16'h0, too[32 - 16 * i +: 16]};
      s = (s & 32'hFFFF) + (s >> 16);
      s = (s & 32'hFFFF) + (s >> 16);
      c = ~s[15:0];
      if (c == 16'h0) c = 16'hFFFF;
      putn(u + 6, 2, c);
    end
    putn(bp + 28, 6, too);
    if (frame_tg) begin
      learned_ip = 32'(getn(bp + 16, 4));
      frame_learned = 1'b1;
    end
  endfunction

  function automatic void push_expected(logic [63:0] w, logic [3:0] c, logic l);
    out_word_t e;
    e.data = w; e.count = c; e.last = l; e.ip = learned_ip; e.learned = frame_learned;
    expected_words.push_back(e);
  endfunction

  function automatic void rewrite_word(frame_word_t it);
    if (line_pos == 0) begin
      frame_tg = it.tg;
      frame_learned = 1'b0;
    end
    if (!it.last) begin
      if (line_pos >= DEPTH) begin
        push_expected(line_w[0], line_c[0], 1'b0);
        for (int i = 0; i < DEPTH - 1; i++) begin
          line_w[i] = line_w[i + 1];
          line_c[i] = line_c[i + 1];
        end
        line_w[DEPTH - 1] = it.data;
        line_c[DEPTH - 1] = it.count;
      end else begin
        line_w[line_pos] = it.data;
        line_c[line_pos] = it.count;
        line_pos++;
        if (line_pos == DEPTH) decide_edits(8 * DEPTH);
      end
      return;
    end
    if (line_pos < DEPTH) begin
      line_w[line_pos] = it.data;
      line_c[line_pos] = it.count;
      decide_edits(8 * line_pos + (it.count > 8 ? 8 : int'(it.count)));
      for (int i = 0; i <= line_pos; i++) push_expected(line_w[i], line_c[i], i == line_pos);
    end else begin
      for (int i = 0; i < DEPTH; i++) push_expected(line_w[i], line_c[i], 1'b0);
      push_expected(it.data, it.count, 1'b1);
    end
    line_pos = 0;
    frame_tg = 1'b0;
    frame_learned = 1'b0;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // frame builder: kind 0 junk, 1 plain ethernet, 2 arp, 3 dhcp
  // ckm 0 random checksum, 1 zero checksum, 2 checksum that folds to zero
  task automatic build_frame(int kind, bit tg, int nbytes, int ihl, int ckm, bit noisy);
    logic [7:0] fr[512];
    logic [47:0] frm, too, m;
    logic [63:0] w;
    frame_word_t it;
    int u, bp, nw, ck;
    frm = tg ? guest_mac : host_mac;
    too = tg ? host_mac : guest_mac;
    for (int i = 0; i < 512; i++) fr[i] = 8'($urandom);
    m = frm;
    if ($urandom_range(99) < 12) m[8 * $urandom_range(5) +: 8] ^= 8'($urandom_range(255, 1));
    if (kind != 0) begin
      if (tg) for (int i = 0; i < 6; i++) fr[i] = m[40 - 8 * i +: 8];
      else for (int i = 0; i < 6; i++) fr[6 + i] = m[40 - 8 * i +: 8];
    end
    if (kind == 2) begin
      {fr[12], fr[13]} = ETH_ARP;
      for (int i = 0; i < 6; i++) fr[(tg ? 32 : 22) + i] = m[40 - 8 * i +: 8];
    end
    if (kind == 3) begin
      {fr[12], fr[13]} = ETH_IP;
      fr[14] = {4'h4, 4'(ihl)};
      fr[23] = IP_UDP;
      u = 14 + 4 * ihl;
      bp = u + 8;
      {fr[u], fr[u + 1]} = tg ? PORT_SERVER : PORT_CLIENT;
      {fr[u + 2], fr[u + 3]} = tg ? PORT_CLIENT : PORT_SERVER;
      ck = ckm == 1 ? 0 : ckm == 2 ? int'(mac_delta(frm, too)) : int'($urandom_range(65535));
      {fr[u + 6], fr[u + 7]} = 16'(ck);
      fr[bp + 1] = HTYPE_ETH;
      fr[bp + 2] = HLEN_ETH;
      for (int i = 0; i < 6; i++) fr[bp + 28 + i] = m[40 - 8 * i +: 8];
    end
    if (noisy) fr[$urandom_range(nbytes < 120 ? nbytes - 1 : 119)] ^= 8'($urandom_range(255, 1));
    nw = (nbytes + 7) / 8;
    for (int k = 0; k < nw; k++) begin
      for (int i = 0; i < 8; i++) w[63 - 8 * i -: 8] = fr[8 * k + i];
      it.data = w;
      it.last = k == nw - 1;
      it.count = it.last ? 4'(nbytes - 8 * k) : 4'd8;
      it.tg = tg;
      if (k > 0 && $urandom_range(99) < 4) it.tg = ~tg;
      if (!it.last && $urandom_range(99) < 3) it.count = 4'($urandom_range(7));
      if (it.last && $urandom_range(99) < 5)
        it.count = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
      pending_words.push_back(it);
    end
  endtask

  task automatic random_frame();
    int kind, ihl, nb, base;
    bit tg;
    kind = $urandom_range(9);
    kind = kind == 0 ? 0 : kind < 3 ? 1 : kind < 5 ? 2 : 3;
    tg = 1'($urandom_range(1));
    ihl = $urandom_range(99) < 85 ? 5 : int'($urandom_range(15));
    base = kind == 0 ? 1 : kind == 1 ? 14 : kind == 2 ? 42 : 14 + 4 * (ihl < 5 ? 5 : ihl) + 42;
    nb = base + $urandom_range(24);
    if ($urandom_range(99) < 10) nb = base > 6 ? base - $urandom_range(6, 1) : 1;
    if ($urandom_range(99) < 5) nb = nb + $urandom_range(200);
    build_frame(kind, tg, nb, ihl, $urandom_range(99) < 10 ? 1 : $urandom_range(99) < 5 ? 2 : 0,
                $urandom_range(99) < 10);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_HOST_MAC) host_mac = val;
    else if (idx == REG_GUEST_MAC) guest_mac = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_tvalid || expected_words.size() > 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic random_phase(int items);
    int target;
    target = pending_words.size() + items;
    while (pending_words.size() < target) random_frame();
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      rewrite_word(cur);
      took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || took) begin
        took = 1'b0;
        if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 19)) begin
          cur = pending_words.pop_front();
          in_tdata <= {4'h0, cur.count, cur.data};
          in_tlast <= cur.last;
          in_tuser <= cur.tg;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= no_idle || $urandom_range(99) >= 19;
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", out_tdata[63:0], '0);
      end else begin
        e = expected_words.pop_front();
        if (out_tdata[63:0] !== e.data) report("out_word", out_tdata[63:0], e.data);
        if (out_tdata[67:64] !== e.count) report("out_count", out_tdata[67:64], e.count);
        if (out_tlast !== e.last) report("out_last", out_tlast, e.last);
        if (out_tdata[99:68] !== e.ip) report("guest_ip", out_tdata[99:68], e.ip);
        if (out_tdata[100] !== e.learned) report("ip_learned", out_tdata[100], e.learned);
      end
    end
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    errors = 0;
    line_pos = 0;
    frame_tg = 1'b0;
    frame_learned = 1'b0;
    learned_ip = '0;
    host_mac = '0;
    guest_mac = '0;
    no_idle = 1'b0;
    took = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames under reset macs, then distinct macs
    build_frame(3, 1'b1, 76, 5, 0, 1'b0);
    drain();
    write_reg(REG_HOST_MAC, 48'h02_11_22_33_44_55);
    write_reg(REG_GUEST_MAC, 48'h0a_66_77_88_99_aa);
    build_frame(3, 1'b1, 80, 5, 0, 1'b0);
    build_frame(3, 1'b0, 80, 5, 1, 1'b0);
    build_frame(3, 1'b1, 76, 5, 2, 1'b0);
    build_frame(3, 1'b1, 75, 5, 0, 1'b0);
    build_frame(3, 1'b1, 80, 4, 0, 1'b0);
    build_frame(2, 1'b1, 38, 5, 0, 1'b0);
    build_frame(2, 1'b0, 28, 5, 0, 1'b0);
    build_frame(1, 1'b1, 6, 5, 0, 1'b0);
    build_frame(1, 1'b0, 13, 5, 0, 1'b0);
    build_frame(1, 1'b0, 150, 5, 0, 1'b0);
    drain();

    random_phase(60);
    write_reg(REG_HOST_MAC, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_GUEST_MAC, 48'h0);
    no_idle = 1'b1;
    random_phase(50);
    no_idle = 1'b0;
    write_reg(REG_HOST_MAC, 48'h0);
    write_reg(REG_GUEST_MAC, 48'hFFFF_FFFF_FFFF);
    random_phase(50);
    write_reg(REG_HOST_MAC, 48'({$urandom, $urandom}));
    write_reg(REG_GUEST_MAC, host_mac);
    random_phase(50);
    write_reg(REG_HOST_MAC, 48'({$urandom, $urandom}));
    write_reg(REG_GUEST_MAC, 48'({$urandom, $urandom}));
    random_phase(50);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
